/* hdl/fbps_pkg.sv */
// Shared types, constants and the fixed color palette of the indexed frame store.
// Depends on nothing; design files use scoped names, the testbench imports it.
package fbps_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned PTR_W      = 17;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CHAN_W     = 8;
  // Clipping sums of a coordinate and a size need one bit more than a field.
  localparam int unsigned SPAN_W     = COORD_W + 1;
  // Scan bounds go up to twice the widest store, so they need two more bits.
  localparam int unsigned CMP_W      = COORD_W + 2;
  // Widest store address for the largest store the block supports.
  localparam int unsigned ADDR_MAX_W = 2 * COORD_W;

  localparam logic [PTR_W-1:0] PTR_MAX     = '1;
  localparam logic [IDX_W-1:0] RESET_INDEX = 4'h2;

  typedef enum logic [OP_W-1:0] {
    OP_SET_ADDR    = 3'd0,
    OP_WRITE_PIXEL = 3'd1,
    OP_WRITE_AT    = 3'd2,
    OP_FILL_RECT   = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_SCAN        = 3'd5
  } cmd_op_e;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    cmd_op_e                op;
    logic [PTR_W-1:0]       address;
    logic [IDX_W-1:0]       color_index;
    logic                   hit;        // target lies inside the store / active area
    logic [ADDR_MAX_W-1:0]  store_addr; // linear store address of the target
    logic [SPAN_W-1:0]      cols;       // clipped rectangle width
    logic [SPAN_W-1:0]      rows;       // clipped rectangle height
  } cmd_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  function automatic rgb_t palette(input logic [IDX_W-1:0] idx);
    rgb_t c;
    case (idx)
      4'd2:    c = '{red: 8'h5C, green: 8'h94, blue: 8'hFC};
      4'd3:    c = '{red: 8'h4C, green: 8'h78, blue: 8'hD8};
      4'd4:    c = '{red: 8'hFC, green: 8'h54, blue: 8'h54};
      4'd5:    c = '{red: 8'hF8, green: 8'hB8, blue: 8'h00};
      4'd6:    c = '{red: 8'h58, green: 8'hD8, blue: 8'h54};
      4'd7:    c = '{red: 8'hD8, green: 8'hA0, blue: 8'h54};
      4'd8:    c = '{red: 8'hA0, green: 8'h54, blue: 8'h2C};
      4'd9:    c = '{red: 8'hC8, green: 8'h84, blue: 8'h2C};
      4'd10:   c = '{red: 8'hD8, green: 8'h98, blue: 8'h5C};
      4'd11:   c = '{red: 8'hA0, green: 8'h54, blue: 8'h2C};
      4'd12:   c = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
      4'd13:   c = '{red: 8'h2C, green: 8'hA8, blue: 8'h2C};
      4'd14:   c = '{red: 8'hFC, green: 8'hBC, blue: 8'h94};
      4'd15:   c = '{red: 8'h40, green: 8'hD0, blue: 8'hFF};
      default: c = '{red: 8'h00, green: 8'h00, blue: 8'h00};
    endcase
    return c;
  endfunction

endpackage

/* hdl/fbps_if.sv */
// Valid/ready channel interfaces: the command stream in and the pixel stream out.
// Depends on fbps_pkg for the field widths.
interface fbps_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [fbps_pkg::OP_W-1:0]            op;
  logic [fbps_pkg::PTR_W-1:0]           address;
  logic [fbps_pkg::COORD_W-1:0]         x_pos;
  logic [fbps_pkg::COORD_W-1:0]         y_pos;
  logic [fbps_pkg::COORD_W-1:0]         rect_width;
  logic [fbps_pkg::COORD_W-1:0]         rect_height;
  logic [fbps_pkg::IDX_W-1:0]           color_index;

  modport source (output valid, op, address, x_pos, y_pos, rect_width, rect_height,
                  color_index, input ready);
  modport sink   (input valid, op, address, x_pos, y_pos, rect_width, rect_height,
                  color_index, output ready);
endinterface

interface fbps_pix_if;
  logic                          valid;
  logic                          ready;
  logic [fbps_pkg::CHAN_W-1:0]   blue;
  logic [fbps_pkg::CHAN_W-1:0]   green;
  logic [fbps_pkg::CHAN_W-1:0]   red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

/* hdl/indexed_framebuffer_palette_scaler.sv */
// Indexed frame store with a 16-entry palette and a 2x scan-out scaler.
// With the queue empty, a scan inside the active area passes through the queue slot, the
// store read register and the output register; a scan outside it skips the store read.
// A scan inside the active area does the store read in ST_IDLE, then the palette in ST_READ;
// any other scan or write is done in ST_IDLE, a rectangle fill writes each clipped pixel
// in ST_FILL and a clear all FB_W*FB_H pixels in ST_CLEAR, all bound by one store write port.
// Reset: a clearing pass writes index 2 to all FB_W*FB_H pixels with cmd_i.ready low.
module indexed_framebuffer_palette_scaler #(
  parameter int unsigned FB_W     = 256,
  parameter int unsigned FB_H     = 240,
  parameter int unsigned OUT_W    = 640,
  parameter int unsigned OUT_H    = 480,
  parameter int unsigned H_OFFSET = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbps_cmd_if.sink    cmd_i,
  fbps_pix_if.source  pix_o
);

  logic            push, pop, full, queue_valid, init;
  fbps_pkg::cmd_t  push_entry, head_entry;

  fbps_front #(
    .FB_W     (FB_W),
    .FB_H     (FB_H),
    .OUT_W    (OUT_W),
    .OUT_H    (OUT_H),
    .H_OFFSET (H_OFFSET)
  ) u_front (
    .cmd     (cmd_i),
    .init_i  (init),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  fbps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (queue_valid),
    .entry_o (head_entry)
  );

  fbps_back #(
    .FB_W (FB_W),
    .FB_H (FB_H)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .entry_i (head_entry),
    .pop_o   (pop),
    .init_o  (init),
    .pix     (pix_o)
  );

endmodule

/* hdl/fbps_front.sv */
// Front end: accepts requests, clips them against the store and computes store addresses.
// Depends on fbps_pkg and fbps_cmd_if; feeds fbps_queue.
module fbps_front #(
  parameter int unsigned FB_W     = 256,
  parameter int unsigned FB_H     = 240,
  parameter int unsigned OUT_W    = 640,
  parameter int unsigned OUT_H    = 480,
  parameter int unsigned H_OFFSET = 64
) (
  fbps_cmd_if.sink         cmd,
  input  logic             init_i,
  input  logic             full_i,
  output logic             push_o,
  output fbps_pkg::cmd_t   entry_o
);

  localparam logic [fbps_pkg::SPAN_W-1:0] FbW = fbps_pkg::SPAN_W'(FB_W);
  localparam logic [fbps_pkg::SPAN_W-1:0] FbH = fbps_pkg::SPAN_W'(FB_H);
  localparam logic [fbps_pkg::CMP_W-1:0]  OutW = fbps_pkg::CMP_W'(OUT_W);
  localparam logic [fbps_pkg::CMP_W-1:0]  OutH = fbps_pkg::CMP_W'(OUT_H);
  localparam logic [fbps_pkg::CMP_W-1:0]  HOff = fbps_pkg::CMP_W'(H_OFFSET);
  localparam logic [fbps_pkg::CMP_W-1:0]  ActW = fbps_pkg::CMP_W'(2 * FB_W);
  localparam logic [fbps_pkg::CMP_W-1:0]  ActH = fbps_pkg::CMP_W'(2 * FB_H);

  localparam int unsigned ProdW = fbps_pkg::COORD_W + fbps_pkg::SPAN_W;

  logic [fbps_pkg::SPAN_W-1:0]  x_s, y_s, col_end, row_end, col_clip, row_clip;
  logic [fbps_pkg::CMP_W-1:0]   x_c, y_c, x_rel;
  logic                         in_store, in_scan;
  logic [fbps_pkg::COORD_W-1:0] row_sel, col_sel;
  logic [ProdW-1:0]             lin_addr;
  logic                         op_known;

  assign cmd.ready = !full_i && !init_i;

  always_comb begin
    x_s      = fbps_pkg::SPAN_W'(cmd.x_pos);
    y_s      = fbps_pkg::SPAN_W'(cmd.y_pos);
    col_end  = x_s + fbps_pkg::SPAN_W'(cmd.rect_width);
    row_end  = y_s + fbps_pkg::SPAN_W'(cmd.rect_height);
    col_clip = (col_end > FbW) ? FbW : col_end;
    row_clip = (row_end > FbH) ? FbH : row_end;
    in_store = (x_s < FbW) && (y_s < FbH);

    x_c     = fbps_pkg::CMP_W'(cmd.x_pos);
    y_c     = fbps_pkg::CMP_W'(cmd.y_pos);
    x_rel   = x_c - HOff;
    in_scan = (x_c < OutW) && (y_c < OutH) && (x_c >= HOff) && (x_rel < ActW) && (y_c < ActH);

    // A scan maps two output pixels onto one store pixel in each direction.
    if (cmd.op == fbps_pkg::OP_SCAN) begin
      row_sel = fbps_pkg::COORD_W'(cmd.y_pos >> 1);
      col_sel = fbps_pkg::COORD_W'(x_rel >> 1);
    end else begin
      row_sel = cmd.y_pos;
      col_sel = cmd.x_pos;
    end
    lin_addr = ProdW'(row_sel) * ProdW'(FbW) + ProdW'(col_sel);
  end

  always_comb begin
    op_known = 1'b1;
    entry_o.op = fbps_pkg::OP_SET_ADDR;
    entry_o.hit = 1'b0;
    unique case (cmd.op)
      fbps_pkg::OP_SET_ADDR: begin
        entry_o.op = fbps_pkg::OP_SET_ADDR;
      end
      fbps_pkg::OP_WRITE_PIXEL: begin
        entry_o.op = fbps_pkg::OP_WRITE_PIXEL;
      end
      fbps_pkg::OP_WRITE_AT: begin
        entry_o.op  = fbps_pkg::OP_WRITE_AT;
        entry_o.hit = in_store;
      end
      fbps_pkg::OP_FILL_RECT: begin
        entry_o.op  = fbps_pkg::OP_FILL_RECT;
        entry_o.hit = in_store && (cmd.rect_width != '0) && (cmd.rect_height != '0);
      end
      fbps_pkg::OP_CLEAR: begin
        entry_o.op = fbps_pkg::OP_CLEAR;
      end
      fbps_pkg::OP_SCAN: begin
        entry_o.op  = fbps_pkg::OP_SCAN;
        entry_o.hit = in_scan;
      end
      default: begin
        op_known = 1'b0;
      end
    endcase
    entry_o.address     = cmd.address;
    entry_o.color_index = cmd.color_index;
    entry_o.store_addr  = fbps_pkg::ADDR_MAX_W'(lin_addr);
    entry_o.cols        = col_clip - x_s;
    entry_o.rows        = row_clip - y_s;
  end

  // Unused op codes are taken off the channel and dropped here.
  assign push_o = cmd.valid && cmd.ready && op_known;

endmodule

/* hdl/fbps_queue.sv */
// Two-entry request queue between the front end and the back end.
// Depends on fbps_pkg for the entry type and depth.
module fbps_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fbps_pkg::cmd_t   entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output fbps_pkg::cmd_t   entry_o
);

  localparam int unsigned CntW = $clog2(fbps_pkg::QUEUE_DEPTH + 1);

  fbps_pkg::cmd_t                  slot_q [fbps_pkg::QUEUE_DEPTH];
  logic [fbps_pkg::QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]                 count_q, count_d;

  assign full_o  = (count_q == CntW'(fbps_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == fbps_pkg::QUEUE_AW'(fbps_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == fbps_pkg::QUEUE_AW'(fbps_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* hdl/fbps_back.sv */
// Back end: owns the pixel store and write pointer, runs fills and clears, and
// performs scan reads through the palette into the output register.
// Depends on fbps_pkg and fbps_pix_if; is fed by fbps_queue.
module fbps_back #(
  parameter int unsigned FB_W = 256,
  parameter int unsigned FB_H = 240
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  fbps_pkg::cmd_t   entry_i,
  output logic             pop_o,
  output logic             init_o,
  fbps_pix_if.source       pix
);

  localparam int unsigned PixCount = FB_W * FB_H;
  localparam int unsigned AW       = $clog2(PixCount);
  localparam int unsigned PtrCmpW  = (fbps_pkg::PTR_W > AW + 1) ? fbps_pkg::PTR_W : AW + 1;
  localparam logic [PtrCmpW-1:0] PixLimit = PtrCmpW'(PixCount);
  localparam logic [AW-1:0]      LastAddr = AW'(PixCount - 1);
  localparam logic [AW-1:0]      RowStep  = AW'(FB_W);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_FILL  = 4'b0100,
    ST_READ  = 4'b1000
  } back_state_e;

  back_state_e                   state_q, state_d;
  logic                          init_q, init_d;
  logic [fbps_pkg::PTR_W-1:0]    ptr_q, ptr_d;
  logic [fbps_pkg::IDX_W-1:0]    fill_idx_q, fill_idx_d;
  logic [AW-1:0]                 sweep_q, sweep_d;
  logic [AW-1:0]                 row_addr_q, row_addr_d;
  logic [fbps_pkg::SPAN_W-1:0]   cols_q, cols_d, col_left_q, col_left_d, row_left_q, row_left_d;

  logic [fbps_pkg::IDX_W-1:0]    mem_q [PixCount];
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [fbps_pkg::IDX_W-1:0]    wdata;
  logic                          rd_en;
  logic [fbps_pkg::IDX_W-1:0]    rd_q;

  logic                          out_valid_q, load_black, load_pal;
  fbps_pkg::rgb_t                out_q, pal;

  logic                          ptr_in;
  logic [AW-1:0]                 ptr_addr;
  logic [AW-1:0]                 entry_addr;

  assign init_o    = init_q;
  assign pix.valid = out_valid_q;
  assign pix.red   = out_q.red;
  assign pix.green = out_q.green;
  assign pix.blue  = out_q.blue;

  assign ptr_in     = (PtrCmpW'(ptr_q) < PixLimit);
  assign ptr_addr   = AW'(PtrCmpW'(ptr_q));
  assign entry_addr = AW'(entry_i.store_addr);
  assign pal        = fbps_pkg::palette(rd_q);

  always_comb begin
    state_d    = state_q;
    init_d     = init_q;
    ptr_d      = ptr_q;
    fill_idx_d = fill_idx_q;
    sweep_d    = sweep_q;
    row_addr_d = row_addr_q;
    cols_d     = cols_q;
    col_left_d = col_left_q;
    row_left_d = row_left_q;
    pop_o      = 1'b0;
    we         = 1'b0;
    waddr      = sweep_q;
    wdata      = fill_idx_q;
    rd_en      = 1'b0;
    load_black = 1'b0;
    load_pal   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          unique case (entry_i.op)
            fbps_pkg::OP_SET_ADDR: begin
              pop_o = 1'b1;
              ptr_d = entry_i.address;
            end
            fbps_pkg::OP_WRITE_PIXEL: begin
              pop_o = 1'b1;
              we    = ptr_in;
              waddr = ptr_addr;
              wdata = entry_i.color_index;
              if (ptr_in && (ptr_q != fbps_pkg::PTR_MAX)) begin
                ptr_d = ptr_q + 1'b1;
              end
            end
            fbps_pkg::OP_WRITE_AT: begin
              pop_o = 1'b1;
              we    = entry_i.hit;
              waddr = entry_addr;
              wdata = entry_i.color_index;
            end
            fbps_pkg::OP_FILL_RECT: begin
              pop_o = 1'b1;
              if (entry_i.hit) begin
                fill_idx_d = entry_i.color_index;
                sweep_d    = entry_addr;
                row_addr_d = entry_addr;
                cols_d     = entry_i.cols;
                col_left_d = entry_i.cols;
                row_left_d = entry_i.rows;
                state_d    = ST_FILL;
              end
            end
            fbps_pkg::OP_CLEAR: begin
              pop_o      = 1'b1;
              fill_idx_d = entry_i.color_index;
              sweep_d    = '0;
              state_d    = ST_CLEAR;
            end
            fbps_pkg::OP_SCAN: begin
              // The output register is free by the time the read data arrives.
              if (!out_valid_q || pix.ready) begin
                pop_o = 1'b1;
                if (entry_i.hit) begin
                  rd_en   = 1'b1;
                  state_d = ST_READ;
                end else begin
                  load_black = 1'b1;
                end
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        we      = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == LastAddr) begin
          init_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        we = 1'b1;
        if (col_left_q == fbps_pkg::SPAN_W'(1)) begin
          if (row_left_q == fbps_pkg::SPAN_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            row_left_d = row_left_q - 1'b1;
            col_left_d = cols_q;
            row_addr_d = row_addr_q + RowStep;
            sweep_d    = row_addr_q + RowStep;
          end
        end else begin
          col_left_d = col_left_q - 1'b1;
          sweep_d    = sweep_q + 1'b1;
        end
      end
      ST_READ: begin
        load_pal = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      init_q      <= 1'b1;
      ptr_q       <= '0;
      fill_idx_q  <= fbps_pkg::RESET_INDEX;
      sweep_q     <= '0;
      row_addr_q  <= '0;
      cols_q      <= '0;
      col_left_q  <= '0;
      row_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_q     <= init_d;
      ptr_q      <= ptr_d;
      fill_idx_q <= fill_idx_d;
      sweep_q    <= sweep_d;
      row_addr_q <= row_addr_d;
      cols_q     <= cols_d;
      col_left_q <= col_left_d;
      row_left_q <= row_left_d;
      if (load_black || load_pal) begin
        out_valid_q <= 1'b1;
      end else if (pix.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_black) begin
      out_q <= '0;
    end else if (load_pal) begin
      out_q <= pal;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[entry_addr];
    end
  end

endmodule

/* dv/indexed_framebuffer_palette_scaler_tb.sv */
// Testbench for the indexed frame store: drives command requests, predicts every scanned
// pixel from its own copy of the store, and checks the BGR stream with random stalls.
// Depends on fbps_pkg, the fbps_cmd_if/fbps_pix_if interfaces and the top-level RTL.
module indexed_framebuffer_palette_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbps_pkg::*;

  localparam int unsigned FB_W     = 256;
  localparam int unsigned FB_H     = 240;
  localparam int unsigned OUT_W    = 640;
  localparam int unsigned OUT_H    = 480;
  localparam int unsigned H_OFFSET = 64;

  localparam int unsigned PIX_COUNT      = FB_W * FB_H;
  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned QUIET_ITEMS    = 150;
  localparam int unsigned SETTLE_CYCLES  = 16;
  // The reset clearing pass, or a clear once the queue fills, blocks requests for a whole frame.
  localparam int unsigned WATCHDOG_LIMIT = 4 * PIX_COUNT + 1000;

  // Op codes the block has no meaning for; they must be swallowed silently.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [PTR_W-1:0]   address;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [IDX_W-1:0]   color_index;
  } cmd_req_t;

  // Shadow frame store and pointer; follows each accepted request, predicts the pixel each scan
  // should produce and checks the pixel stream against them in order.
  class scan_scoreboard;
    bit [IDX_W-1:0] frame [PIX_COUNT];
    bit [PTR_W-1:0] wr_ptr;
    rgb_t           lut [16];
    rgb_t           pending_pixels [$];
    int unsigned    mismatches;
    int unsigned    pixels_checked;

    function new();
      lut = '{24'h000000, 24'h000000, 24'h5C94FC, 24'h4C78D8,
              24'hFC5454, 24'hF8B800, 24'h58D854, 24'hD8A054,
              24'hA0542C, 24'hC8842C, 24'hD8985C, 24'hA0542C,
              24'hFFFFFF, 24'h2CA82C, 24'hFCBC94, 24'h40D0FF};
      foreach (frame[i]) frame[i] = RESET_INDEX;
      wr_ptr = '0;
      mismatches = 0;
      pixels_checked = 0;
    endfunction

    function void note_request(cmd_req_t req);
      int unsigned x, y, row_end, col_end;
      bit          in_area;
      rgb_t        px;
      x = 32'(req.x_pos);
      y = 32'(req.y_pos);
      case (req.op)
        OP_SET_ADDR: wr_ptr = req.address;
        OP_WRITE_PIXEL: begin
          if (wr_ptr < PIX_COUNT) begin
            frame[wr_ptr] = req.color_index;
            if (wr_ptr < PTR_MAX) wr_ptr++;
          end
        end
        OP_WRITE_AT: begin
          if (x < FB_W && y < FB_H) frame[y * FB_W + x] = req.color_index;
        end
        OP_FILL_RECT: begin
          row_end = (y + req.rect_height > FB_H) ? FB_H : y + req.rect_height;
          col_end = (x + req.rect_width > FB_W) ? FB_W : x + req.rect_width;
          for (int unsigned r = y; r < row_end; r++)
            for (int unsigned c = x; c < col_end; c++)
              frame[r * FB_W + c] = req.color_index;
        end
        OP_CLEAR: foreach (frame[i]) frame[i] = req.color_index;
        OP_SCAN: begin
          in_area = x < OUT_W && y < OUT_H && x >= H_OFFSET &&
                    x - H_OFFSET < 2 * FB_W && y < 2 * FB_H;
          px = '0;
          if (in_area) px = lut[frame[(y >> 1) * FB_W + ((x - H_OFFSET) >> 1)]];
          pending_pixels.push_back(px);
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel with no scan pending: red %0h green %0h blue %0h",
               got.red, got.green, got.blue);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (got.blue !== want.blue) begin
        $error("blue: expected %0h, got %0h", want.blue, got.blue);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0h, got %0h", want.green, got.green);
        mismatches++;
      end
      if (got.red !== want.red) begin
        $error("red: expected %0h, got %0h", want.red, got.red);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fbps_cmd_if cmd_bus ();
  fbps_pix_if pix_bus ();

  indexed_framebuffer_palette_scaler #(
    .FB_W    (FB_W),
    .FB_H    (FB_H),
    .OUT_W   (OUT_W),
    .OUT_H   (OUT_H),
    .H_OFFSET(H_OFFSET)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .pix_o (pix_bus)
  );

  scan_scoreboard board;
  int unsigned    requests_sent = 0;
  int unsigned    clears_sent   = 0;
  int unsigned    fills_sent    = 0;
  int unsigned    gap_pct       = 0;
  bit             quiet_phase   = 1'b0;
  int unsigned    idle_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic cmd_req_t rand_req(input logic [OP_W-1:0] op);
    cmd_req_t req;
    req.op          = op;
    req.address     = PTR_W'($urandom_range(0, 'h1FFFF));
    req.x_pos       = COORD_W'($urandom_range(0, 1023));
    req.y_pos       = COORD_W'($urandom_range(0, 1023));
    req.rect_width  = COORD_W'($urandom_range(0, 1023));
    req.rect_height = COORD_W'($urandom_range(0, 1023));
    req.color_index = IDX_W'($urandom_range(0, 15));
    return req;
  endfunction

  task automatic send_req(input cmd_req_t req);
    @(negedge clk_i);
    cmd_bus.valid       <= 1'b1;
    cmd_bus.op          <= req.op;
    cmd_bus.address     <= req.address;
    cmd_bus.x_pos       <= req.x_pos;
    cmd_bus.y_pos       <= req.y_pos;
    cmd_bus.rect_width  <= req.rect_width;
    cmd_bus.rect_height <= req.rect_height;
    cmd_bus.color_index <= req.color_index;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    board.note_request(req);
    requests_sent++;
    if (req.op == OP_CLEAR) clears_sent++;
    if (req.op == OP_FILL_RECT) fills_sent++;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk_i);
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk_i);
    end
  endtask

  task automatic send_at(input logic [OP_W-1:0] op, input int unsigned x, input int unsigned y,
                         input int unsigned w, input int unsigned h, input int unsigned idx);
    cmd_req_t req;
    req = rand_req(op);
    req.x_pos       = COORD_W'(x);
    req.y_pos       = COORD_W'(y);
    req.rect_width  = COORD_W'(w);
    req.rect_height = COORD_W'(h);
    req.color_index = IDX_W'(idx);
    send_req(req);
  endtask

  // Scan one of the four output pixels that show a given store pixel.
  task automatic scan_store_pixel(input int unsigned col, input int unsigned row);
    send_at(OP_SCAN, H_OFFSET + 2 * col + $urandom_range(0, 1), 2 * row + $urandom_range(0, 1),
            0, 0, 0);
  endtask

  task automatic set_pointer(input int unsigned addr);
    cmd_req_t req;
    req = rand_req(OP_SET_ADDR);
    req.address = PTR_W'(addr);
    send_req(req);
  endtask

  task automatic wait_for_pixels();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Pixel sink: random back-pressure bursts, with long stall-free stretches mixed in.
  initial begin
    pix_bus.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        pix_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        pix_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 20) == 0) begin
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_bus.valid && pix_bus.ready)
      board.check_pixel('{red: pix_bus.red, green: pix_bus.green, blue: pix_bus.blue});
  end

  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned target, base, n, col, row, clears_left;
    board = new();
    rst_ni              = 1'b0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.op          = OP_SET_ADDR;
    cmd_bus.address     = '0;
    cmd_bus.x_pos       = '0;
    cmd_bus.y_pos       = '0;
    cmd_bus.rect_width  = '0;
    cmd_bus.rect_height = '0;
    cmd_bus.color_index = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: active-area edges, clipping, pointer past the store end, spare ops.
    gap_pct = 30;
    send_at(OP_SCAN, H_OFFSET, 0, 0, 0, 0);
    send_at(OP_SCAN, H_OFFSET - 1, 0, 0, 0, 0);
    send_at(OP_SCAN, H_OFFSET + 2 * FB_W, 0, 0, 0, 0);
    send_at(OP_SCAN, H_OFFSET, 2 * FB_H, 0, 0, 0);
    send_at(OP_SCAN, 1023, 1023, 0, 0, 0);
    send_at(OP_WRITE_AT, 0, 0, 0, 0, 15);
    send_at(OP_WRITE_AT, FB_W - 1, FB_H - 1, 0, 0, 12);
    send_at(OP_WRITE_AT, FB_W, 0, 0, 0, 7);
    send_at(OP_WRITE_AT, 1023, 1023, 0, 0, 7);
    send_at(OP_SCAN, H_OFFSET + 1, 1, 0, 0, 0);
    send_at(OP_SCAN, H_OFFSET + 2 * FB_W - 1, 2 * FB_H - 1, 0, 0, 0);
    set_pointer(PIX_COUNT - 2);
    repeat (3) send_req(rand_req(OP_WRITE_PIXEL));
    scan_store_pixel(FB_W - 2, FB_H - 1);
    scan_store_pixel(FB_W - 1, FB_H - 1);
    set_pointer(PTR_MAX);
    send_req(rand_req(OP_WRITE_PIXEL));
    send_req(rand_req(OP_SPARE_6));
    send_req(rand_req(OP_SPARE_7));
    send_at(OP_FILL_RECT, FB_W - 6, FB_H - 5, 1023, 1023, 5);
    send_at(OP_FILL_RECT, 10, 10, 0, 5, 4);
    send_at(OP_FILL_RECT, FB_W + 44, 0, 4, 4, 4);
    scan_store_pixel(FB_W - 3, FB_H - 2);
    // Hold new requests back until every pending pixel has come out.
    wait_for_pixels();
    send_at(OP_CLEAR, 0, 0, 0, 0, 9);
    scan_store_pixel(FB_W / 2, FB_H / 2);

    // Random part: mostly well-formed write-then-read sequences.
    target = requests_sent + RANDOM_ITEMS;
    clears_left = 2;
    while (requests_sent < target) begin
      quiet_phase = (requests_sent + QUIET_ITEMS >= target);
      gap_pct = (quiet_phase || $urandom_range(0, 3) == 0) ? 0 : 35;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          base = ($urandom_range(0, 5) == 0) ? $urandom_range(PIX_COUNT - 6, PIX_COUNT + 2)
                                             : $urandom_range(0, PIX_COUNT - 1);
          set_pointer(base);
          n = $urandom_range(1, 8);
          repeat (n) send_req(rand_req(OP_WRITE_PIXEL));
          for (int unsigned k = 0; k < n; k++)
            if (base + k < PIX_COUNT) scan_store_pixel((base + k) % FB_W, (base + k) / FB_W);
        end
        6, 7, 8, 9: begin
          col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, FB_W - 1);
          row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, FB_H - 1);
          send_at(OP_WRITE_AT, col, row, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 15));
          if (col < FB_W && row < FB_H) scan_store_pixel(col, row);
        end
        10, 11: begin
          // Keep the clipped area small so fills stay cheap.
          if ($urandom_range(0, 3) == 0) begin
            col = $urandom_range(FB_W - 8, 1023);
            row = $urandom_range(FB_H - 8, 1023);
            send_at(OP_FILL_RECT, col, row, $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 15));
          end else begin
            col = $urandom_range(0, FB_W - 1);
            row = $urandom_range(0, FB_H - 1);
            send_at(OP_FILL_RECT, col, row, $urandom_range(0, 12), $urandom_range(0, 12),
                    $urandom_range(0, 15));
          end
          if (col < FB_W && row < FB_H) scan_store_pixel(col, row);
          if (col + 1 < FB_W && row + 1 < FB_H) scan_store_pixel(col + 1, row + 1);
        end
        12, 13, 14, 15, 16, 17: begin
          repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 3) != 0)
              scan_store_pixel($urandom_range(0, FB_W - 1), $urandom_range(0, FB_H - 1));
            else
              send_req(rand_req(OP_SCAN));
          end
        end
        18: begin
          repeat ($urandom_range(2, 5)) begin
            case ($urandom_range(0, 3))
              0:       send_req(rand_req(OP_SET_ADDR));
              1:       send_req(rand_req(OP_WRITE_PIXEL));
              2:       send_req(rand_req($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7));
              default: send_req(rand_req(OP_SCAN));
            endcase
          end
        end
        default: begin
          if (clears_left != 0 && !quiet_phase) begin
            clears_left--;
            send_req(rand_req(OP_CLEAR));
            repeat (3) scan_store_pixel($urandom_range(0, FB_W - 1), $urandom_range(0, FB_H - 1));
          end
        end
      endcase
    end

    wait_for_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests (%0d rectangle fills, %0d clears); %0d scanned pixels checked.",
             requests_sent, fills_sent, clears_sent, board.pixels_checked);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
